### hw/rtl/mmq_pkg.sv
// shared types, widths and constants for the min/max linear quantizer
// no dependencies; imported by every module of the block
`default_nettype none

package mmq_pkg;

  localparam int DATA_W       = 32;
  localparam int SAMPLE_WIDTH = 32;
  localparam int SAMPLE_SHIFT = DATA_W - SAMPLE_WIDTH;

  localparam int SPAN_W    = DATA_W + 1;
  localparam int DIFF_W    = DATA_W + 1;
  localparam int SCALED_W  = DIFF_W + 16;
  localparam int NUM_W     = SCALED_W + 1;
  localparam int MAG_W     = NUM_W - 1;
  localparam int NUMER_W   = MAG_W + 2;
  localparam int DIV_W     = SPAN_W + 1;
  localparam int Q_W       = 17;
  localparam int Q_CNT_W   = $clog2(Q_W + 1);
  localparam int CODE_W    = 16;
  localparam int SCALE_SH  = 16;
  localparam int OFFSET_SH = 15;

  localparam logic signed [DATA_W-1:0] SAMPLE_MAX =
    DATA_W'((longint'(1) << (SAMPLE_WIDTH - 1)) - longint'(1));
  localparam logic signed [DATA_W-1:0] SAMPLE_MIN =
    DATA_W'(-(longint'(1) << (SAMPLE_WIDTH - 1)));

  localparam logic signed [CODE_W-1:0] CODE_MAX  = 16'sh7fff;
  localparam logic signed [CODE_W-1:0] CODE_MIN  = 16'sh8000;
  localparam logic [Q_W-1:0]           Q_POS_LIM = 17'd32767;
  localparam logic [Q_W-1:0]           Q_NEG_LIM = 17'd32768;

  localparam logic [1:0] ACT_SCAN   = 2'd0;
  localparam logic [1:0] ACT_FINISH = 2'd1;
  localparam logic [1:0] ACT_QUANT  = 2'd2;
  localparam logic [1:0] ACT_IGNORE = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] low;
    logic signed [DATA_W-1:0] high;
    logic [SPAN_W-1:0]        span;
    logic                     empty;
  } held_t;

  typedef struct packed {
    logic done;
    logic sat;
  } div_status_t;

  // keep the low SAMPLE_WIDTH bits as two's complement
  function automatic logic signed [DATA_W-1:0] read_sample(logic signed [DATA_W-1:0] raw);
    logic signed [DATA_W-1:0] sh;
    sh = raw <<< SAMPLE_SHIFT;
    return sh >>> SAMPLE_SHIFT;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/mmq_range.sv
// running min/max tracker and latched quantizer bounds
// depends on mmq_pkg
`default_nettype none

module mmq_range (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             scan_en,
  input  wire logic                             finish_en,
  input  wire logic signed [mmq_pkg::DATA_W-1:0] x,
  output mmq_pkg::held_t                        held
);
  import mmq_pkg::*;

  logic signed [DATA_W-1:0] scan_low;
  logic signed [DATA_W-1:0] scan_high;
  logic                     scan_seen;
  logic [SPAN_W-1:0]        span_next;

  assign span_next = {scan_high[DATA_W-1], scan_high} - {scan_low[DATA_W-1], scan_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_low   <= SAMPLE_MAX;
      scan_high  <= SAMPLE_MIN;
      scan_seen  <= 1'b0;
      held.low   <= '0;
      held.high  <= '0;
      held.span  <= '0;
      held.empty <= 1'b1;
    end else if (finish_en) begin
      if (scan_seen) begin
        held.low   <= scan_low;
        held.high  <= scan_high;
        held.span  <= span_next;
        held.empty <= 1'b0;
      end else begin
        held.low   <= '0;
        held.high  <= '0;
        held.span  <= '0;
        held.empty <= 1'b1;
      end
      scan_low  <= SAMPLE_MAX;
      scan_high <= SAMPLE_MIN;
      scan_seen <= 1'b0;
    end else if (scan_en) begin
      if (x < scan_low) begin
        scan_low <= x;
      end
      if (x > scan_high) begin
        scan_high <= x;
      end
      scan_seen <= 1'b1;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mmq_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on mmq_pkg; quotient limited to Q_W bits with a saturation flag
`default_nettype none

module mmq_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [mmq_pkg::NUMER_W-1:0]   numer,
  input  wire logic [mmq_pkg::DIV_W-1:0]     divisor,
  output logic [mmq_pkg::Q_W-1:0]            quo,
  output mmq_pkg::div_status_t               status
);
  import mmq_pkg::*;

  logic [DIV_W-1:0]   rem;
  logic [DIV_W-1:0]   dvs;
  logic [Q_W-1:0]     nbits;
  logic [Q_CNT_W-1:0] cnt;
  logic               run;
  logic [DIV_W:0]     trial;
  logic [DIV_W:0]     trial_sub;
  logic               fits;

  assign trial     = {rem, nbits[Q_W-1]};
  assign fits      = trial >= {1'b0, dvs};
  assign trial_sub = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run         <= 1'b0;
      cnt         <= '0;
      status.done <= 1'b0;
      status.sat  <= 1'b0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        dvs <= divisor;
        quo <= '0;
        // top bits already at or above the divisor: quotient needs more than Q_W bits
        if (numer[NUMER_W-1:Q_W] >= divisor) begin
          status.sat  <= 1'b1;
          status.done <= 1'b1;
          run         <= 1'b0;
        end else begin
          status.sat <= 1'b0;
          rem        <= numer[NUMER_W-1:Q_W];
          nbits      <= numer[Q_W-1:0];
          cnt        <= Q_CNT_W'(Q_W);
          run        <= 1'b1;
        end
      end else if (run) begin
        if (fits) begin
          rem <= trial_sub[DIV_W-1:0];
        end else begin
          rem <= trial[DIV_W-1:0];
        end
        quo   <= {quo[Q_W-2:0], fits};
        nbits <= {nbits[Q_W-2:0], 1'b0};
        cnt   <= cnt - 1'b1;
        if (cnt == Q_CNT_W'(1)) begin
          run         <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/minmax_linear_quantizer_16bit.sv
// min/max linear quantizer, top level; uses mmq_pkg, mmq_range, mmq_div
// scan transactions: one per cycle while in_stall is low, no result
// finish transactions: result registered from S_FIN once the output is free; input stalls until then
// quantize transactions: result registered from S_FIN once the output is free; input stalls throughout,
//   through five wide prep steps and the bit-serial divider (a zero span goes straight to S_FIN)
// synchronous reset clears the scan, empties the bounds and drops out_valid
`default_nettype none

module minmax_linear_quantizer_16bit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        action,
  input  wire logic signed [mmq_pkg::DATA_W-1:0] sample,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [mmq_pkg::CODE_W-1:0]      code,
  output logic signed [mmq_pkg::DATA_W-1:0]      range_low,
  output logic signed [mmq_pkg::DATA_W-1:0]      range_high,
  output logic                                   empty_res
);
  import mmq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_SCALE,
    S_OFFSET,
    S_MAG,
    S_NUMER,
    S_START,
    S_DIV,
    S_FIN
  } state_t;

  state_t                     state;
  logic                       in_acc;
  logic                       scan_en;
  logic                       finish_en;
  logic                       quant_en;
  logic signed [DATA_W-1:0]   x_in;
  logic signed [DATA_W-1:0]   x_r;
  logic signed [DIFF_W-1:0]   diff_r;
  logic signed [SCALED_W-1:0] scaled_r;
  logic signed [NUM_W-1:0]    num_r;
  logic                       neg_r;
  logic [MAG_W-1:0]           mag_r;
  logic [NUMER_W-1:0]         numer_r;
  logic signed [CODE_W-1:0]   code_r;
  logic signed [CODE_W-1:0]   code_next;
  logic                       out_free;
  held_t                      held;
  div_status_t                div_st;
  logic [Q_W-1:0]             quo;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign x_in     = read_sample(sample);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    scan_en   = 1'b0;
    finish_en = 1'b0;
    quant_en  = 1'b0;
    unique case (action)
      ACT_SCAN:   scan_en   = in_acc;
      ACT_FINISH: finish_en = in_acc;
      ACT_QUANT:  quant_en  = in_acc;
      default:    ;
    endcase
  end

  mmq_range u_range (
    .clk       (clk),
    .rst       (rst),
    .scan_en   (scan_en),
    .finish_en (finish_en),
    .x         (x_in),
    .held      (held)
  );

  mmq_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (state == S_START),
    .numer   (numer_r),
    .divisor ({held.span, 1'b0}),
    .quo     (quo),
    .status  (div_st)
  );

  // round-half-away quotient, then saturate to the code range on each side
  always_comb begin
    if (neg_r) begin
      if (div_st.sat || quo > Q_NEG_LIM) begin
        code_next = CODE_MIN;
      end else begin
        code_next = -signed'(quo[CODE_W-1:0]);
      end
    end else begin
      if (div_st.sat || quo > Q_POS_LIM) begin
        code_next = CODE_MAX;
      end else begin
        code_next = signed'(quo[CODE_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          x_r    <= x_in;
          code_r <= '0;
          if (finish_en) begin
            state <= S_FIN;
          end else if (quant_en) begin
            if (held.span == '0) begin
              state <= S_FIN;
            end else begin
              state <= S_DIFF;
            end
          end
        end
        S_DIFF: begin
          diff_r <= {x_r[DATA_W-1], x_r} - {held.low[DATA_W-1], held.low};
          state  <= S_SCALE;
        end
        S_SCALE: begin
          // times 65535
          scaled_r <= (SCALED_W'(diff_r) <<< SCALE_SH) - SCALED_W'(diff_r);
          state    <= S_OFFSET;
        end
        S_OFFSET: begin
          num_r <= NUM_W'(scaled_r) - (NUM_W'(held.span) << OFFSET_SH);
          state <= S_MAG;
        end
        S_MAG: begin
          neg_r <= num_r[NUM_W-1];
          if (num_r[NUM_W-1]) begin
            mag_r <= MAG_W'(-num_r);
          end else begin
            mag_r <= MAG_W'(num_r);
          end
          state <= S_NUMER;
        end
        S_NUMER: begin
          numer_r <= NUMER_W'({mag_r, 1'b0}) + NUMER_W'(held.span);
          state   <= S_START;
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_st.done) begin
            code_r <= code_next;
            state  <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            code       <= code_r;
            range_low  <= held.low;
            range_high <= held.high;
            empty_res  <= held.empty;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_quant_busy: assert property (@(posedge clk) disable iff (rst)
    (quant_en && held.span != '0) |=> in_stall)
    else $error("quantize transaction did not hold off the input");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == S_DIV))
    else $error("divider finished outside the divide phase");

  a_empty_bounds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_res) |-> (range_low == '0 && range_high == '0))
    else $error("empty result carries nonzero bounds");

  a_span_match: assert property (@(posedge clk) disable iff (rst)
    held.span == SPAN_W'({held.high[DATA_W-1], held.high} - {held.low[DATA_W-1], held.low}))
    else $error("latched span disagrees with latched bounds");
`endif

endmodule

`default_nettype wire

### bench/minmax_linear_quantizer_16bit_tb.sv
// self-checking bench for minmax_linear_quantizer_16bit: a code predictor in a
// scoreboard class, plain tasks that drive the valid/stall channels
// depends on mmq_pkg and the minmax_linear_quantizer_16bit rtl
`timescale 1ns / 1ps

class quant_scoreboard;
  typedef struct {
    logic signed [mmq_pkg::CODE_W-1:0] code;
    logic signed [mmq_pkg::DATA_W-1:0] low;
    logic signed [mmq_pkg::DATA_W-1:0] high;
    logic                              empty;
  } quant_result_t;

  localparam longint CODE_STEPS = 65535;
  localparam longint HALF_STEPS = 32768;
  localparam longint Q_LIMIT    = 65536;
  localparam longint T_MAX      = 32767;
  localparam longint T_MIN      = -32768;
  localparam int     EXT_SHIFT  = 64 - mmq_pkg::SAMPLE_WIDTH;

  longint scan_low;
  longint scan_high;
  bit     scan_seen;
  longint held_low;
  longint held_span;
  bit     held_empty;

  quant_result_t expected_codes[$];
  int accepted;
  int checked;
  int failures;

  function new();
    clear_scan();
    held_low   = 0;
    held_span  = 0;
    held_empty = 1'b1;
    accepted   = 0;
    checked    = 0;
    failures   = 0;
  endfunction

  function void clear_scan();
    scan_low  = mmq_pkg::SAMPLE_MAX;
    scan_high = mmq_pkg::SAMPLE_MIN;
    scan_seen = 1'b0;
  endfunction

  function int pending();
    return expected_codes.size();
  endfunction

  // update the predicted state for one accepted transaction
  function void note_input(logic [1:0] act, logic signed [mmq_pkg::DATA_W-1:0] raw);
    longint        x;
    longint        num;
    longint        mag;
    longint        q;
    longint        t;
    quant_result_t r;
    accepted++;
    x = raw;
    x = (x <<< EXT_SHIFT) >>> EXT_SHIFT;
    r.code = '0;
    case (act)
      mmq_pkg::ACT_SCAN: begin
        if (x < scan_low) scan_low = x;
        if (x > scan_high) scan_high = x;
        scan_seen = 1'b1;
        return;
      end
      mmq_pkg::ACT_FINISH: begin
        if (scan_seen) begin
          held_low   = scan_low;
          held_span  = scan_high - scan_low;
          held_empty = 1'b0;
        end else begin
          held_low   = 0;
          held_span  = 0;
          held_empty = 1'b1;
        end
        clear_scan();
      end
      mmq_pkg::ACT_QUANT: begin
        if (held_span != 0) begin
          // exact (x-low)*65535/span - 32768, half away from zero
          num = (x - held_low) * CODE_STEPS - HALF_STEPS * held_span;
          mag = (num < 0) ? -num : num;
          q   = (2 * mag + held_span) / (2 * held_span);
          if (q > Q_LIMIT) q = Q_LIMIT;
          t = (num < 0) ? -q : q;
          if (t > T_MAX) t = T_MAX;
          if (t < T_MIN) t = T_MIN;
          r.code = mmq_pkg::CODE_W'(t);
        end
      end
      default: return;
    endcase
    r.low   = mmq_pkg::DATA_W'(held_low);
    r.high  = mmq_pkg::DATA_W'(held_low + held_span);
    r.empty = held_empty;
    expected_codes.push_back(r);
  endfunction

  function void report(string what, logic signed [31:0] exp_v, logic signed [31:0] act_v);
    failures++;
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
  endfunction

  function void check_result(logic signed [mmq_pkg::CODE_W-1:0] c,
                             logic signed [mmq_pkg::DATA_W-1:0] lo,
                             logic signed [mmq_pkg::DATA_W-1:0] hi,
                             logic e);
    quant_result_t r;
    if (expected_codes.size() == 0) begin
      failures++;
      $display("%0t: result with no transaction pending: code %0d low %0d high %0d empty %0b",
               $time, c, lo, hi, e);
      return;
    end
    r = expected_codes.pop_front();
    checked++;
    if (c !== r.code) report("code", r.code, c);
    if (lo !== r.low) report("range_low", r.low, lo);
    if (hi !== r.high) report("range_high", r.high, hi);
    if (e !== r.empty) report("empty_res", r.empty, e);
  endfunction
endclass

module minmax_linear_quantizer_16bit_tb;
  import mmq_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 220;
  localparam int TAIL_CYCLES  = 40;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  logic [1:0]               action    = ACT_SCAN;
  logic signed [DATA_W-1:0] sample    = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [CODE_W-1:0] code;
  logic signed [DATA_W-1:0] range_low;
  logic signed [DATA_W-1:0] range_high;
  logic                     empty_res;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_request   = 1'b0;

  quant_scoreboard board;

  minmax_linear_quantizer_16bit DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code       (code),
    .range_low  (range_low),
    .range_high (range_high),
    .empty_res  (empty_res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // offer one transaction, hold it until accepted
  task automatic offer_item(input logic [1:0] act, input logic [DATA_W-1:0] smp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    sample   <= smp;
    do @(posedge clk); while (in_stall);
    board.note_input(act, smp);
  endtask

  task automatic wait_for_codes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin : receiver
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        board.check_result(code, range_low, range_high, empty_res);
      if (hold_request) begin
        hold = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("minmax_linear_quantizer_16bit regression: fail");
    $finish;
  end

  initial begin : stimulus
    logic [DATA_W-1:0] center;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] smp;
    logic [DATA_W-1:0] scanned[$];
    int phase;
    int items;
    int nscan;
    int nquant;
    int pick;
    int e;
    board = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // bounds never latched, then an empty finish
    offer_item(ACT_QUANT, 32'd0);
    offer_item(ACT_QUANT, SAMPLE_MIN);
    offer_item(ACT_FINISH, 32'hdead_beef);
    offer_item(ACT_IGNORE, 32'hffff_ffff);
    offer_item(ACT_QUANT, 32'd5);
    // full-scale span
    offer_item(ACT_SCAN, SAMPLE_MIN);
    offer_item(ACT_SCAN, SAMPLE_MAX);
    offer_item(ACT_FINISH, 32'd0);
    offer_item(ACT_QUANT, SAMPLE_MIN);
    offer_item(ACT_QUANT, SAMPLE_MAX);
    offer_item(ACT_QUANT, 32'd0);
    offer_item(ACT_QUANT, 32'hffff_ffff);
    offer_item(ACT_QUANT, 32'h5555_5555);
    // single sample gives zero span but not empty
    offer_item(ACT_SCAN, 32'd1234);
    offer_item(ACT_FINISH, 32'hffff_ffff);
    offer_item(ACT_QUANT, 32'd1234);
    offer_item(ACT_QUANT, SAMPLE_MAX);
    // small span: saturation outside the bounds and a half-way rounding
    offer_item(ACT_SCAN, -32'sd100);
    offer_item(ACT_SCAN, 32'sd100);
    offer_item(ACT_IGNORE, 32'd7);
    offer_item(ACT_FINISH, 32'd0);
    offer_item(ACT_QUANT, -32'sd101);
    offer_item(ACT_QUANT, 32'sd101);
    offer_item(ACT_QUANT, 32'sd0);
    offer_item(ACT_QUANT, 32'sd100);
    wait_for_codes();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          // output held off while input keeps coming
          hold_request   = 1'b1;
        end
        1: begin
          send_idle_pct  = 77;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 77;
        end
        default: begin
          send_idle_pct  = 27;
          recv_stall_pct = 27;
        end
      endcase
      items = 0;
      while (items < PHASE_ITEMS) begin
        if ($urandom_range(0, 19) == 0) begin
          offer_item(ACT_FINISH, $urandom);
          items++;
        end
        nscan  = $urandom_range(1, 6);
        e      = $urandom_range(0, 32);
        mask   = (e == 32) ? 32'hffff_ffff : (32'd1 << e) - 32'd1;
        center = $urandom;
        scanned.delete();
        repeat (nscan) begin
          smp = center + ($urandom & mask);
          scanned.push_back(smp);
          offer_item(ACT_SCAN, smp);
          items++;
          if ($urandom_range(0, 9) == 0) offer_item(ACT_IGNORE, $urandom);
        end
        // now and then the scan stays open and carries into the next set
        if ($urandom_range(0, 9) != 0) begin
          offer_item(ACT_FINISH, $urandom);
          items++;
        end
        nquant = $urandom_range(1, 6);
        repeat (nquant) begin
          pick = $urandom_range(0, 99);
          if (pick < 60) smp = center + ($urandom & mask);
          else if (pick < 75) smp = scanned[$urandom_range(0, scanned.size() - 1)];
          else if (pick < 92) smp = $urandom;
          else if (pick < 96) smp = SAMPLE_MIN;
          else smp = SAMPLE_MAX;
          offer_item(ACT_QUANT, smp);
          items++;
        end
      end
      // sender pauses until every code is back
      wait_for_codes();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("ran %0d transactions and checked %0d results", board.accepted, board.checked);
    $display("mixes: no idling, sender idle, receiver stall, both, plus a %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("minmax_linear_quantizer_16bit regression: pass");
    end else begin
      $display("minmax_linear_quantizer_16bit regression: fail");
    end
    $finish;
  end
endmodule

### files.f
hw/rtl/mmq_pkg.sv
hw/rtl/mmq_range.sv
hw/rtl/mmq_div.sv
hw/rtl/minmax_linear_quantizer_16bit.sv
bench/minmax_linear_quantizer_16bit_tb.sv
